// ----- hw/rtl/vog_pkg.sv -----
// ----------------------------------------------------------------------------
// vog_pkg
// Shared types and constants of the voxel occupancy grid store.
// ----------------------------------------------------------------------------
package vog_pkg;

	localparam int GRID_X_DEF = 64;
	localparam int GRID_Y_DEF = 64;
	localparam int GRID_Z_DEF = 64;

	localparam int POS_W  = 24;
	localparam int RES_W  = 16;
	localparam int EXT_W  = 7;
	localparam int LIM_W  = 9;
	localparam int CODE_W = 2;
	localparam int IDX_W  = 3;
	localparam int BIT_W  = 4;
	localparam int CMP_W  = 32;

	localparam logic [IDX_W-1:0] REG_RES = 3'd0;
	localparam logic [IDX_W-1:0] REG_OX  = 3'd1;
	localparam logic [IDX_W-1:0] REG_OY  = 3'd2;
	localparam logic [IDX_W-1:0] REG_OZ  = 3'd3;
	localparam logic [IDX_W-1:0] REG_EX  = 3'd4;
	localparam logic [IDX_W-1:0] REG_EY  = 3'd5;
	localparam logic [IDX_W-1:0] REG_EZ  = 3'd6;

	localparam logic [CODE_W-1:0] CODE_UNMAPPED = 2'd0;
	localparam logic [CODE_W-1:0] CODE_EMPTY    = 2'd1;
	localparam logic [CODE_W-1:0] CODE_OCCUPIED = 2'd2;
	localparam logic [CODE_W-1:0] CODE_OOB      = 2'd3;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [BIT_W-1:0] bitpos;
	} div_ctl_t;

endpackage

// ----- hw/rtl/vog_if.sv -----
// ----------------------------------------------------------------------------
// vog channel interfaces
// Input, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vog_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  operation;
	logic signed [vog_pkg::POS_W-1:0]      pos_x;
	logic signed [vog_pkg::POS_W-1:0]      pos_y;
	logic signed [vog_pkg::POS_W-1:0]      pos_z;
	logic [vog_pkg::CODE_W-1:0]            write_code;
	modport source (output valid, operation, pos_x, pos_y, pos_z, write_code,
		input ready);
	modport sink (input valid, operation, pos_x, pos_y, pos_z, write_code,
		output ready);
endinterface

interface vog_out_if;
	logic                       valid;
	logic                       ready;
	logic [vog_pkg::CODE_W-1:0] occupancy;
	logic                       inside_res;
	modport source (output valid, occupancy, inside_res, input ready);
	modport sink (input valid, occupancy, inside_res, output ready);
endinterface

interface vog_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [vog_pkg::IDX_W-1:0]   index;
	logic [vog_pkg::POS_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/vog_axis_div.sv -----
// ----------------------------------------------------------------------------
// vog_axis_div
// Bounds check and restoring division of one axis, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module vog_axis_div #(
	parameter int QW = 6,
	parameter int IW = 6
) (
	input  logic                             clk,
	input  vog_pkg::div_ctl_t                ctl,
	input  logic signed [vog_pkg::POS_W:0]   diff,
	input  logic [vog_pkg::RES_W-1:0]        res,
	input  logic [vog_pkg::LIM_W-1:0]        lim,
	output logic                             in_range,
	output logic [IW-1:0]                    idx
);
	import vog_pkg::*;

	logic                    neg_q;
	logic [POS_W-1:0]        rem_q;
	logic [QW-1:0]           quo_q;
	logic [POS_W:0]          bound;
	logic [CMP_W-1:0]        sub_sh;
	logic                    take;

	assign bound    = (POS_W+1)'(lim) * (POS_W+1)'(res);
	assign in_range = !neg_q && (res != '0) && ({1'b0, rem_q} < bound);
	assign sub_sh   = CMP_W'(res) << ctl.bitpos;
	assign take     = CMP_W'(rem_q) >= sub_sh;
	assign idx      = quo_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			neg_q <= diff[POS_W];
			rem_q <= diff[POS_W-1:0];
			quo_q <= '0;
		end else if (ctl.step) begin
			if (take) begin
				rem_q <= rem_q - sub_sh[POS_W-1:0];
			end
			quo_q <= (quo_q << 1) | QW'(take);
		end
	end

endmodule

// ----- hw/rtl/voxel_occupancy_grid_store.sv -----
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_store
// 3D occupancy grid of 2-bit voxel codes with quantizing position lookup.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of its power-of-two sized memory
// (262144 at the default size) and accepts no word during that pass. Each
// word then passes the offset and bounds check, the bit-serial dividers, which
// work on all three axes at once and produce a quotient as wide as that of the
// widest axis (6 bits at the default size), a memory access and the output
// register. Out-of-bounds words skip the dividers and memory. One word is
// processed at a time, and the next word can be accepted once the result has
// been loaded into the output register.
module voxel_occupancy_grid_store #(
	parameter int GRID_X = vog_pkg::GRID_X_DEF,
	parameter int GRID_Y = vog_pkg::GRID_Y_DEF,
	parameter int GRID_Z = vog_pkg::GRID_Z_DEF
) (
	input logic     clk,
	input logic     arst_n,
	vog_in_if.sink    in_w,
	vog_out_if.source out_w,
	vog_cfg_if.sink   cfg
);
	import vog_pkg::*;

	localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
	localparam int QW = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
	localparam int AW = XW + YW + ZW;
	localparam int DEPTH = 1 << AW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_MEM   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]              state_q;
	logic [AW-1:0]           clr_q;
	logic [BIT_W-1:0]        bit_q;
	logic [RES_W-1:0]        res_q;
	logic signed [POS_W-1:0] ox_q, oy_q, oz_q;
	logic [EXT_W-1:0]        ex_q, ey_q, ez_q;
	logic                    op_q;
	logic [CODE_W-1:0]       code_q;
	logic                    hit_q;
	logic [CODE_W-1:0]       rd_q;
	logic                    ovalid_q;
	logic [CODE_W-1:0]       occ_q;
	logic                    ins_q;
	logic [CODE_W-1:0]       mem [DEPTH];

	logic                    in_acc;
	logic                    inside_x, inside_y, inside_z, inside_all;
	logic [XW-1:0]           xi;
	logic [YW-1:0]           yi;
	logic [ZW-1:0]           zi;
	logic [LIM_W-1:0]        lim_x, lim_y, lim_z;
	logic signed [POS_W:0]   dx, dy, dz;
	div_ctl_t                dctl;
	logic                    mem_we;
	logic [AW-1:0]           mem_addr;
	logic [CODE_W-1:0]       mem_wd;
	logic                    out_free;

	assign in_acc     = in_w.valid && in_w.ready;
	assign in_w.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign out_free   = !ovalid_q || out_w.ready;

	assign out_w.valid      = ovalid_q;
	assign out_w.occupancy  = occ_q;
	assign out_w.inside_res = ins_q;

	assign lim_x = ({2'b0, ex_q} > LIM_W'(GRID_X)) ? LIM_W'(GRID_X) : {2'b0, ex_q};
	assign lim_y = ({2'b0, ey_q} > LIM_W'(GRID_Y)) ? LIM_W'(GRID_Y) : {2'b0, ey_q};
	assign lim_z = ({2'b0, ez_q} > LIM_W'(GRID_Z)) ? LIM_W'(GRID_Z) : {2'b0, ez_q};

	assign dx = (POS_W+1)'(in_w.pos_x) - (POS_W+1)'(ox_q);
	assign dy = (POS_W+1)'(in_w.pos_y) - (POS_W+1)'(oy_q);
	assign dz = (POS_W+1)'(in_w.pos_z) - (POS_W+1)'(oz_q);

	assign dctl.load   = in_acc;
	assign dctl.step   = (state_q == ST_DIV);
	assign dctl.bitpos = bit_q;

	assign inside_all = inside_x && inside_y && inside_z;

	vog_axis_div #(.QW(QW), .IW(XW)) u_div_x (
		.clk(clk), .ctl(dctl), .diff(dx), .res(res_q), .lim(lim_x),
		.in_range(inside_x), .idx(xi));
	vog_axis_div #(.QW(QW), .IW(YW)) u_div_y (
		.clk(clk), .ctl(dctl), .diff(dy), .res(res_q), .lim(lim_y),
		.in_range(inside_y), .idx(yi));
	vog_axis_div #(.QW(QW), .IW(ZW)) u_div_z (
		.clk(clk), .ctl(dctl), .diff(dz), .res(res_q), .lim(lim_z),
		.in_range(inside_z), .idx(zi));

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = {xi, yi, zi};
		mem_wd   = code_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				mem_wd   = CODE_UNMAPPED;
			end
			ST_MEM: begin
				mem_we = (op_q == OP_WRITE);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_W'(16);
			ox_q  <= '0;
			oy_q  <= '0;
			oz_q  <= '0;
			ex_q  <= EXT_W'(64);
			ey_q  <= EXT_W'(64);
			ez_q  <= EXT_W'(64);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RES: res_q <= cfg.data[RES_W-1:0];
				REG_OX:  ox_q  <= cfg.data;
				REG_OY:  oy_q  <= cfg.data;
				REG_OZ:  oz_q  <= cfg.data;
				REG_EX:  ex_q  <= cfg.data[EXT_W-1:0];
				REG_EY:  ey_q  <= cfg.data[EXT_W-1:0];
				REG_EZ:  ez_q  <= cfg.data[EXT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in_w.operation;
			code_q <= in_w.write_code;
		end
		if (state_q == ST_CHECK) begin
			hit_q <= inside_all;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			bit_q    <= '0;
			ovalid_q <= 1'b0;
			occ_q    <= CODE_UNMAPPED;
			ins_q    <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && out_w.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					bit_q   <= BIT_W'(QW - 1);
					state_q <= inside_all ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == '0) begin
						state_q <= ST_MEM;
					end
				end
				ST_MEM: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						ins_q    <= hit_q;
						if (!hit_q) begin
							occ_q <= CODE_OOB;
						end else if (op_q == OP_WRITE) begin
							occ_q <= code_q;
						end else begin
							occ_q <= rd_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == ST_IDLE) else $error("word accepted while busy");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_CHECK) else $error("accepted word not checked");

	a_oob_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_w.valid && !out_w.inside_res) |-> out_w.occupancy == CODE_OOB)
		else $error("outside result without out-of-bounds code");

	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> out_w.valid && state_q == ST_IDLE)
		else $error("result not loaded");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the voxel occupancy grid store against its own model of the grid:
// directed corner words, then random reads and writes over several register
// settings, with random gaps on the input and stalls on the result channel.
// ----------------------------------------------------------------------------
module tb_top;
	import vog_pkg::*;

	localparam int GX = GRID_X_DEF;
	localparam int GY = GRID_Y_DEF;
	localparam int GZ = GRID_Z_DEF;
	localparam int WATCH_LIMIT = 1200000;
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic             operation;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_z;
		logic [CODE_W-1:0] write_code;
	} voxel_req_t;

	typedef struct packed {
		logic [CODE_W-1:0] occupancy;
		logic              inside_res;
	} voxel_res_t;

	logic clk;
	logic arst_n;

	vog_in_if  in_w ();
	vog_out_if out_w ();
	vog_cfg_if cfg ();

	voxel_occupancy_grid_store u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_w   (in_w.sink),
		.out_w  (out_w.source),
		.cfg    (cfg.sink)
	);

	logic [CODE_W-1:0] grid_mem [GX*GY*GZ];
	logic [RES_W-1:0]  m_res;
	logic [POS_W-1:0]  m_org [3];
	logic [EXT_W-1:0]  m_ext [3];

	voxel_req_t pending_words [$];
	voxel_res_t expected_occ [$];
	int gap_pct;
	int stall_pct;
	bit hold_off;
	bit failed;
	bit cfg_busy;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit quantize(input logic [POS_W-1:0] p,
		input logic [POS_W-1:0] o, input logic [EXT_W-1:0] e, input int grid,
		output int idx);
		longint diff;
		longint q;
		int lim;
		diff = longint'($signed(p)) - longint'($signed(o));
		lim = (int'(e) > grid) ? grid : int'(e);
		idx = 0;
		if (m_res == 0 || diff < 0)
			return 1'b0;
		q = diff / longint'(m_res);
		if (q >= lim)
			return 1'b0;
		idx = int'(q);
		return 1'b1;
	endfunction

	function automatic voxel_res_t grid_access(input voxel_req_t w);
		voxel_res_t r;
		int xi, yi, zi, addr;
		bit in_x, in_y, in_z;
		in_x = quantize(w.pos_x, m_org[0], m_ext[0], GX, xi);
		in_y = quantize(w.pos_y, m_org[1], m_ext[1], GY, yi);
		in_z = quantize(w.pos_z, m_org[2], m_ext[2], GZ, zi);
		if (!(in_x && in_y && in_z)) begin
			r.occupancy = CODE_OOB;
			r.inside_res = 1'b0;
			return r;
		end
		addr = (xi * GY + yi) * GZ + zi;
		if (w.operation == OP_WRITE)
			grid_mem[addr] = w.write_code;
		r.occupancy = grid_mem[addr];
		r.inside_res = 1'b1;
		return r;
	endfunction

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		voxel_req_t w;
		if (!arst_n) begin
			in_w.valid <= 1'b0;
			in_w.operation <= OP_READ;
			in_w.pos_x <= '0;
			in_w.pos_y <= '0;
			in_w.pos_z <= '0;
			in_w.write_code <= '0;
		end else begin
			if (in_w.valid && in_w.ready) begin
				w = {in_w.operation, in_w.pos_x, in_w.pos_y, in_w.pos_z, in_w.write_code};
				expected_occ.push_back(grid_access(w));
			end
			if ((!in_w.valid || in_w.ready) ) begin
				if (pending_words.size() > 0 && !(hold_off && expected_occ.size() > 0)
					&& !cfg_busy && $urandom_range(99) >= gap_pct) begin
					w = pending_words.pop_front();
					in_w.valid <= 1'b1;
					{in_w.operation, in_w.pos_x, in_w.pos_y, in_w.pos_z, in_w.write_code} <= w;
				end else begin
					in_w.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		voxel_res_t e;
		if (!arst_n) begin
			out_w.ready <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)
				|| (cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_w.valid && out_w.ready) begin
				if (expected_occ.size() == 0) begin
					$error("unexpected word: occupancy %0d inside_res %0d",
						out_w.occupancy, out_w.inside_res);
					failed = 1'b1;
				end else begin
					e = expected_occ.pop_front();
					if (out_w.occupancy !== e.occupancy) begin
						$error("occupancy expected %0d actual %0d", e.occupancy, out_w.occupancy);
						failed = 1'b1;
					end
					if (out_w.inside_res !== e.inside_res) begin
						$error("inside_res expected %0d actual %0d", e.inside_res,
							out_w.inside_res);
						failed = 1'b1;
					end
				end
			end
			out_w.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			REG_RES: m_res = d[RES_W-1:0];
			REG_OX:  m_org[0] = d;
			REG_OY:  m_org[1] = d;
			REG_OZ:  m_org[2] = d;
			REG_EX:  m_ext[0] = d[EXT_W-1:0];
			REG_EY:  m_ext[1] = d[EXT_W-1:0];
			REG_EZ:  m_ext[2] = d[EXT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || expected_occ.size() > 0 || in_w.valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic settle_config(input logic [RES_W-1:0] r,
		input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
		input logic [POS_W-1:0] oz, input logic [EXT_W-1:0] ex,
		input logic [EXT_W-1:0] ey, input logic [EXT_W-1:0] ez);
		drain();
		cfg_busy = 1'b1;
		reg_write(REG_RES, POS_W'(r));
		reg_write(REG_OX, ox);
		reg_write(REG_OY, oy);
		reg_write(REG_OZ, oz);
		reg_write(REG_EX, POS_W'(ex));
		reg_write(REG_EY, POS_W'(ey));
		reg_write(REG_EZ, POS_W'(ez));
		reg_write(REG_SPARE, POS_W'($urandom));
		cfg.valid <= 1'b0;
		cfg_busy = 1'b0;
	endtask

	function automatic logic [POS_W-1:0] axis_pos(input logic [POS_W-1:0] o,
		input int ext);
		longint span;
		span = longint'(m_res) * (ext + 2);
		case ($urandom_range(9))
			0: return POS_W'($urandom);
			1: return o - POS_W'($urandom_range(3));
			default: return o + POS_W'(longint'($urandom) % (span > 0 ? span : 1));
		endcase
	endfunction

	task automatic queue_random(input int n);
		voxel_req_t w;
		repeat (n) begin
			w.operation = 1'($urandom_range(1));
			w.pos_x = axis_pos(m_org[0], int'(m_ext[0]));
			w.pos_y = axis_pos(m_org[1], int'(m_ext[1]));
			w.pos_z = axis_pos(m_org[2], int'(m_ext[2]));
			w.write_code = CODE_W'($urandom_range(3));
			pending_words.push_back(w);
		end
	endtask

	task automatic add_word(input logic op, input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
		input logic [CODE_W-1:0] c);
		pending_words.push_back({op, x, y, z, c});
	endtask

	initial begin
		for (int i = 0; i < GX*GY*GZ; i++)
			grid_mem[i] = CODE_UNMAPPED;
		m_res = RES_W'(16);
		m_org = '{default: '0};
		m_ext = '{default: 7'd64};
		failed = 1'b0;
		hold_off = 1'b0;
		cfg_busy = 1'b0;
		gap_pct = 15;
		stall_pct = 86;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_word(OP_READ, 24'd0, 24'd0, 24'd0, CODE_UNMAPPED);
		add_word(OP_WRITE, 24'd0, 24'd0, 24'd0, CODE_OCCUPIED);
		add_word(OP_READ, 24'd15, 24'd15, 24'd15, CODE_UNMAPPED);
		add_word(OP_WRITE, 24'd1023, 24'd1023, 24'd1023, CODE_OOB);
		add_word(OP_READ, 24'd1023, 24'd1023, 24'd1023, CODE_UNMAPPED);
		add_word(OP_WRITE, 24'd1024, 24'd0, 24'd0, CODE_EMPTY);
		add_word(OP_READ, 24'hFFFFFF, 24'd0, 24'd0, CODE_UNMAPPED);
		add_word(OP_WRITE, 24'h800000, 24'h7FFFFF, 24'd5, CODE_EMPTY);
		add_word(OP_WRITE, 24'd16, 24'd32, 24'd48, CODE_EMPTY);
		add_word(OP_READ, 24'd16, 24'd32, 24'd48, CODE_UNMAPPED);
		add_word(OP_WRITE, 24'd16, 24'd32, 24'd48, CODE_UNMAPPED);
		drain();
		hold_off = 1'b0;

		settle_config(16'd0, 24'd0, 24'd0, 24'd0, 7'd64, 7'd64, 7'd64);
		add_word(OP_WRITE, 24'd0, 24'd0, 24'd0, CODE_OCCUPIED);
		add_word(OP_READ, 24'd5, 24'd5, 24'd5, CODE_UNMAPPED);
		settle_config(16'd1, 24'h800000, 24'h7FFFC0, 24'hFFFFF0, 7'd0, 7'd64, 7'd1);
		add_word(OP_READ, 24'h800000, 24'h7FFFC0, 24'hFFFFF0, CODE_UNMAPPED);
		settle_config(16'd1, 24'h800000, 24'h7FFFC0, 24'hFFFFF0, 7'd127, 7'd64, 7'd1);
		add_word(OP_WRITE, 24'h800000, 24'h7FFFC0, 24'hFFFFF0, CODE_OOB);
		add_word(OP_READ, 24'h80003F, 24'h7FFFFF, 24'hFFFFF0, CODE_UNMAPPED);
		add_word(OP_READ, 24'h800040, 24'h7FFFFF, 24'hFFFFF0, CODE_UNMAPPED);
		settle_config(16'hFFFF, 24'h7FFFFF, 24'd0, 24'h800000, 7'd64, 7'd64, 7'd64);
		add_word(OP_WRITE, 24'h7FFFFF, 24'hFFFFFF, 24'h7FFFFF, CODE_EMPTY);
		add_word(OP_READ, 24'h7FFFFF, 24'h3FFFFF, 24'h7FFFFF, CODE_UNMAPPED);

		settle_config(16'd16, 24'd0, 24'd0, 24'd0, 7'd4, 7'd4, 7'd4);
		queue_random(300);
		drain();
		hold_off = 1'b1;
		queue_random(50);
		drain();
		hold_off = 1'b0;

		gap_pct = 86;
		stall_pct = 15;
		settle_config(16'd3, 24'hFFFF00, 24'd100, 24'hFFFFE0, 7'd64, 7'd2, 7'd33);
		queue_random(350);
		settle_config(16'd1, 24'd0, 24'd0, 24'd0, 7'd1, 7'd1, 7'd1);
		queue_random(100);

		gap_pct = 0;
		stall_pct = 0;
		settle_config(16'd40, 24'h000123, 24'hFFF000, 24'd7, 7'd64, 7'd64, 7'd64);
		queue_random(400);
		settle_config(16'd2, 24'd0, 24'd0, 24'd0, 7'd3, 7'd3, 7'd3);
		queue_random(250);
		drain();
		repeat (50) @(posedge clk);

		if (!failed && expected_occ.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/vog_pkg.sv
hw/rtl/vog_if.sv
hw/rtl/vog_axis_div.sv
hw/rtl/voxel_occupancy_grid_store.sv
sim/tb_top.sv
